[rtl/sspf_pkg.sv]
// Package: constants and helpers for the servo short packet framer.
package sspf_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] pay_cnt_t;
  typedef logic [3:0] pos_t;

  localparam byte_t    HDR_FIRST     = 8'hFA;
  localparam byte_t    HDR_SECOND    = 8'hAF;
  localparam pay_cnt_t MAX_PAYLOAD   = 3'd4;

  // byte positions within a packet
  localparam pos_t POS_HDR_FIRST  = 4'd0;
  localparam pos_t POS_HDR_SECOND = 4'd1;
  localparam pos_t POS_ID         = 4'd2;
  localparam pos_t POS_FLAGS      = 4'd3;
  localparam pos_t POS_ADDR       = 4'd4;
  localparam pos_t POS_LENGTH     = 4'd5;
  localparam pos_t POS_COUNT      = 4'd6;
  localparam pos_t POS_PAY0       = 4'd7;
  localparam pos_t POS_PAY1       = 4'd8;
  localparam pos_t POS_PAY2       = 4'd9;
  localparam pos_t POS_PAY3       = 4'd10;

  typedef struct packed {
    byte_t       servo_id;
    byte_t       flag_bits;
    byte_t       reg_address;
    byte_t       length_byte;
    byte_t       count_byte;
    pay_cnt_t    n;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } cmd_t;

  function automatic pay_cnt_t sat_count(input logic [2:0] raw);
    sat_count = (raw > MAX_PAYLOAD) ? MAX_PAYLOAD : raw;
  endfunction

  function automatic byte_t packet_sum(input cmd_t c);
    byte_t s;
    s = c.servo_id ^ c.flag_bits ^ c.reg_address ^ c.length_byte ^ c.count_byte;
    if (c.n > 3'd0) s = s ^ c.first_word[7:0];
    if (c.n > 3'd1) s = s ^ c.first_word[15:8];
    if (c.n > 3'd2) s = s ^ c.second_word[7:0];
    if (c.n > 3'd3) s = s ^ c.second_word[15:8];
    packet_sum = s;
  endfunction

endpackage

[rtl/servo_short_packet_framer_top.sv]
// Servo short packet framer: one command in, an 8 to 12 byte packet out.
//
// Command channel: a command is taken at a rising edge with start high and
// busy low. One command can wait in a holding register while the previous
// packet is still going out, so busy rises the cycle after a command is
// taken and falls when that command moves on to the serializer.
// Result channel: each packet byte is on out_byte for one cycle with strobe
// high; last_of_packet marks the checksum byte. The receiver cannot stall,
// so bytes leave at one per cycle without gaps inside a packet.
// Timing: a taken command goes from the holding register to the serializer
// registers and then to the output registers before its first header byte
// appears, when the serializer is free. The payload count saturates at 4,
// and with commands kept waiting the packets follow each other with no idle
// cycle; the byte counter in the serializer sets the pace.
// Reset (rst, synchronous) empties the holding register and the serializer
// and drops strobe; a packet in flight is abandoned.
module servo_short_packet_framer_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sspf_pkg::byte_t   servo_id,
  input  sspf_pkg::byte_t   flag_bits,
  input  sspf_pkg::byte_t   reg_address,
  input  sspf_pkg::byte_t   length_byte,
  input  sspf_pkg::byte_t   count_byte,
  input  logic [2:0]        payload_bytes,
  input  logic [15:0]       first_word,
  input  logic [15:0]       second_word,
  output logic              strobe,
  output sspf_pkg::byte_t   out_byte,
  output logic              last_of_packet
);
  import sspf_pkg::*;

  cmd_t  pend;
  logic  pend_valid;
  cmd_t  act;
  byte_t act_sum;
  pos_t  act_idx;
  logic  act_valid;

  pos_t  last_idx;
  logic  act_last;
  logic  load_act;
  logic  accept;
  byte_t sel_byte;

  assign busy     = pend_valid;
  assign accept   = start && !busy;
  assign last_idx = POS_PAY0 + pos_t'(act.n);
  assign act_last = act_valid && (act_idx == last_idx);
  assign load_act = pend_valid && (!act_valid || act_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (load_act) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend.servo_id    <= servo_id;
      pend.flag_bits   <= flag_bits;
      pend.reg_address <= reg_address;
      pend.length_byte <= length_byte;
      pend.count_byte  <= count_byte;
      pend.n           <= sat_count(payload_bytes);
      pend.first_word  <= first_word;
      pend.second_word <= second_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      act_idx   <= POS_HDR_FIRST;
    end else if (load_act) begin
      act_valid <= 1'b1;
      act_idx   <= POS_HDR_FIRST;
    end else if (act_last) begin
      act_valid <= 1'b0;
    end else if (act_valid) begin
      act_idx <= act_idx + 4'd1;
    end
  end

  // checksum is fixed per command, so it is folded once on load
  always_ff @(posedge clk) begin
    if (load_act) begin
      act     <= pend;
      act_sum <= packet_sum(pend);
    end
  end

  always_comb begin
    case (act_idx)
      POS_HDR_FIRST:  sel_byte = HDR_FIRST;
      POS_HDR_SECOND: sel_byte = HDR_SECOND;
      POS_ID:         sel_byte = act.servo_id;
      POS_FLAGS:      sel_byte = act.flag_bits;
      POS_ADDR:       sel_byte = act.reg_address;
      POS_LENGTH:     sel_byte = act.length_byte;
      POS_COUNT:      sel_byte = act.count_byte;
      POS_PAY0:       sel_byte = act.first_word[7:0];
      POS_PAY1:       sel_byte = act.first_word[15:8];
      POS_PAY2:       sel_byte = act.second_word[7:0];
      POS_PAY3:       sel_byte = act.second_word[15:8];
      default:        sel_byte = act_sum;
    endcase
    if (act_last) sel_byte = act_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= act_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_byte       <= sel_byte;
    last_of_packet <= act_last;
  end

  a_new_packet_header: assert property (@(posedge clk) disable iff (rst)
    load_act |=> ##1 (strobe && out_byte == HDR_FIRST && !last_of_packet))
    else $error("packet did not open with first header byte");

  a_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_of_packet) |=> (!strobe || out_byte == HDR_FIRST))
    else $error("byte after checksum is not a new header");

  a_last_has_strobe: assert property (@(posedge clk) disable iff (rst)
    last_of_packet |-> strobe)
    else $error("last_of_packet without strobe");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("command taken but busy did not rise");

endmodule

[bench/tb.sv]
// Self-checking bench for the servo short packet framer: directed and random commands.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sspf_pkg::*;

  typedef struct {
    byte_t       id;
    byte_t       flags;
    byte_t       addr;
    byte_t       len;
    byte_t       cnt;
    logic [2:0]  npay;
    logic [15:0] w1;
    logic [15:0] w2;
  } servo_cmd_t;

  typedef struct {
    byte_t value;
    logic  last;
  } tx_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  byte_t       servo_id;
  byte_t       flag_bits;
  byte_t       reg_address;
  byte_t       length_byte;
  byte_t       count_byte;
  logic [2:0]  payload_bytes;
  logic [15:0] first_word;
  logic [15:0] second_word;
  logic        strobe;
  byte_t       out_byte;
  logic        last_of_packet;

  tx_byte_t pending_bytes[$];
  int       errors = 0;
  bit       idle_gaps = 1'b1;

  servo_short_packet_framer_top uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .servo_id       (servo_id),
    .flag_bits      (flag_bits),
    .reg_address    (reg_address),
    .length_byte    (length_byte),
    .count_byte     (count_byte),
    .payload_bytes  (payload_bytes),
    .first_word     (first_word),
    .second_word    (second_word),
    .strobe         (strobe),
    .out_byte       (out_byte),
    .last_of_packet (last_of_packet)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #1ms;
    $display("** servo_short_packet_framer_top: FAILED **");
    $finish;
  end

  // Expected wire bytes for one command: header, body, payload, XOR checksum.
  function automatic void frame_packet(input servo_cmd_t c);
    byte_t frame [11];
    int    nbytes;
    byte_t sum;
    frame = '{HDR_FIRST, HDR_SECOND, c.id, c.flags, c.addr, c.len, c.cnt,
              c.w1[7:0], c.w1[15:8], c.w2[7:0], c.w2[15:8]};
    nbytes = 7 + ((c.npay > MAX_PAYLOAD) ? int'(MAX_PAYLOAD) : int'(c.npay));
    sum = '0;
    for (int k = 0; k < nbytes; k++) begin
      if (k >= 2) sum ^= frame[k];
      pending_bytes.push_back(tx_byte_t'{frame[k], 1'b0});
    end
    pending_bytes.push_back(tx_byte_t'{sum, 1'b1});
  endfunction

  function automatic servo_cmd_t make_cmd(input byte_t id, input byte_t flags,
                                          input byte_t addr, input byte_t len,
                                          input byte_t cnt, input logic [2:0] npay,
                                          input logic [15:0] w1, input logic [15:0] w2);
    servo_cmd_t c;
    c.id = id;
    c.flags = flags;
    c.addr = addr;
    c.len = len;
    c.cnt = cnt;
    c.npay = npay;
    c.w1 = w1;
    c.w2 = w2;
    return c;
  endfunction

  function automatic servo_cmd_t rand_cmd();
    return make_cmd(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                    byte_t'($urandom), byte_t'($urandom), 3'($urandom_range(0, 7)),
                    16'($urandom), 16'($urandom));
  endfunction

  // One command beat; start stays high on return so back-to-back beats need no toggle.
  task automatic send_cmd(input servo_cmd_t c);
    if (idle_gaps && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start         <= 1'b1;
    servo_id      <= c.id;
    flag_bits     <= c.flags;
    reg_address   <= c.addr;
    length_byte   <= c.len;
    count_byte    <= c.cnt;
    payload_bytes <= c.npay;
    first_word    <= c.w1;
    second_word   <= c.w2;
    do @(posedge clk); while (busy);
    frame_packet(c);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %h last %b",
                 $time, out_byte, last_of_packet);
        errors++;
      end else begin
        if (out_byte !== pending_bytes[0].value) begin
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, pending_bytes[0].value, out_byte);
          errors++;
        end
        if (last_of_packet !== pending_bytes[0].last) begin
          $display("%0t: last_of_packet mismatch: expected %b, actual %b",
                   $time, pending_bytes[0].last, last_of_packet);
          errors++;
        end
        void'(pending_bytes.pop_front());
      end
    end
  end

  task automatic test_field_extremes();
    send_cmd(make_cmd(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000));
    send_cmd(make_cmd(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 16'hFFFF, 16'hFFFF));
    send_cmd(make_cmd(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 3'd4, 16'h55AA, 16'h55AA));
    send_cmd(make_cmd(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 3'd4, 16'hAA55, 16'hAA55));
  endtask

  // distinct payload bytes expose any byte-order slip
  task automatic test_payload_counts();
    for (int n = 0; n <= 4; n++)
      send_cmd(make_cmd(8'h01, 8'h00, 8'h1E, 8'h02, 8'h01, n[2:0], 16'h2211, 16'h4433));
  endtask

  task automatic test_count_saturation();
    for (int n = 5; n <= 7; n++)
      send_cmd(make_cmd(8'h7F, 8'h01, 8'h24, 8'h04, 8'h01, n[2:0], 16'hBEEF, 16'hCAFE));
  endtask

  // bytes past the payload count must stay out of the packet and the checksum
  task automatic test_unused_words();
    send_cmd(make_cmd(8'h03, 8'h00, 8'h30, 8'h01, 8'h01, 3'd0, 16'hFFFF, 16'hFFFF));
    send_cmd(make_cmd(8'h04, 8'h00, 8'h31, 8'h01, 8'h01, 3'd1, 16'hFF5A, 16'hFFFF));
    send_cmd(make_cmd(8'h05, 8'h00, 8'h32, 8'h02, 8'h01, 3'd2, 16'h1234, 16'hA5A5));
    send_cmd(make_cmd(8'h06, 8'h00, 8'h33, 8'h03, 8'h01, 3'd3, 16'h0F0F, 16'hFF00));
  endtask

  task automatic test_flag_commands();
    send_cmd(make_cmd(8'hFF, 8'h40, 8'hFF, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000));
    send_cmd(make_cmd(8'h01, 8'h20, 8'hFF, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000));
    send_cmd(make_cmd(8'hFF, 8'h10, 8'hFF, 8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000));
  endtask

  task automatic test_drain_pause();
    repeat (6) send_cmd(rand_cmd());
    wait_drained();
    repeat (6) send_cmd(rand_cmd());
    wait_drained();
  endtask

  task automatic test_random_commands();
    for (int k = 0; k < 340; k++) begin
      idle_gaps = ((k / 40) % 2) == 0;
      send_cmd(rand_cmd());
    end
  endtask

  task automatic test_back_to_back();
    idle_gaps = 1'b0;
    repeat (24) send_cmd(rand_cmd());
  endtask

  initial begin
    rst           <= 1'b1;
    start         <= 1'b0;
    servo_id      <= '0;
    flag_bits     <= '0;
    reg_address   <= '0;
    length_byte   <= '0;
    count_byte    <= '0;
    payload_bytes <= '0;
    first_word    <= '0;
    second_word   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_payload_counts();
    test_count_saturation();
    test_unused_words();
    test_flag_commands();
    test_drain_pause();
    test_random_commands();
    test_back_to_back();

    wait_drained();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("** servo_short_packet_framer_top: PASSED **");
    end else begin
      $display("** servo_short_packet_framer_top: FAILED **");
    end
    $finish;
  end

endmodule
